// ===== rtl/rsta_pkg.sv =====
package rsta_pkg;

	// table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// field widths
	localparam int ADDR_W = 16;
	localparam int TIME_W = 32;
	localparam int THR_W  = 5;
	localparam int OUT_CNT_W = 5;
	localparam int SLOT_W = ADDR_W + TIME_W;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	// largest count that the result field can show
	localparam logic [OUT_CNT_W-1:0] COUNT_MAX = 5'd31;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd1;

	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd3840;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 5'd3;

	// request kinds
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic             start;
		logic             issue;
		logic [IDX_W-1:0] issue_idx;
		logic             commit;
	} rsta_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rsta_status_t;

endpackage

// ===== rtl/rsta_ram.sv =====
module rsta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/rsta_ctrl.sv =====
module rsta_ctrl import rsta_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output rsta_cmd_t    cmd,
	input  rsta_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FLUSH  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             flush_q;

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd.start     = s_tvalid && s_tready;
		cmd.issue     = (state_q == ST_SCAN);
		cmd.issue_idx = idx_q;
		cmd.commit    = (state_q == ST_COMMIT) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
						flush_q <= 1'b0;
					end
				end
				// the read and age stages drain here before the commit
				ST_FLUSH: begin
					flush_q <= 1'b1;
					if (flush_q) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rsta_dp.sv =====
module rsta_dp import rsta_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  rsta_cmd_t            cmd,
	output rsta_status_t         status,
	input  logic [TIME_W-1:0]    timeout,
	input  logic [THR_W-1:0]     threshold,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	// latched request
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;

	// live flags, one per slot
	logic [ENTRIES-1:0] slot_valid_q;

	// read stage
	logic              iss_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SLOT_W-1:0] rdata;
	logic [ADDR_W-1:0] rd_addr;
	logic [TIME_W-1:0] rd_time;

	// age stage
	logic              iss_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [TIME_W-1:0] age_s2;
	logic              valid_s2;
	logic              match_s2;

	// scan results
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              hit_live_q;
	logic              emp_q;
	logic [IDX_W-1:0]  emp_idx_q;
	logic [TIME_W-1:0] best_age_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              best_live_q;
	logic [CNT_W-1:0]  live_cnt_q;

	logic                 expired;
	logic                 live;
	logic                 older;
	logic [IDX_W-1:0]     pick_idx;
	logic                 pick_live;
	logic                 rec_we;
	logic [CNT_W-1:0]     cnt_new;
	logic [OUT_CNT_W-1:0] cnt_sat;
	logic                 alarm;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	rsta_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (pick_idx),
		.wdata ({addr_q, now_q}),
		.raddr (cmd.issue_idx),
		.rdata (rdata)
	);

	assign rd_addr = rdata[SLOT_W-1:TIME_W];
	assign rd_time = rdata[TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= s_tuser;
			addr_q <= s_tdata[ADDR_W-1:0];
			now_q  <= s_tdata[ADDR_W +: TIME_W];
		end
		idx_s1   <= cmd.issue_idx;
		idx_s2   <= idx_s1;
		age_s2   <= now_q - rd_time;
		valid_s2 <= slot_valid_q[idx_s1];
		match_s2 <= slot_valid_q[idx_s1] && (rd_addr == addr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
			iss_s2 <= 1'b0;
		end else begin
			iss_s1 <= cmd.issue;
			iss_s2 <= iss_s1;
		end
	end

	always_comb begin
		expired = valid_s2 && (age_s2 > timeout);
		live    = valid_s2 && !expired;
		older   = (idx_s2 == '0) || (age_s2 > best_age_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_live_q  <= 1'b0;
			emp_q       <= 1'b0;
			emp_idx_q   <= '0;
			best_age_q  <= '0;
			best_idx_q  <= '0;
			best_live_q <= 1'b0;
			live_cnt_q  <= '0;
		end else if (cmd.start) begin
			hit_q      <= 1'b0;
			emp_q      <= 1'b0;
			live_cnt_q <= '0;
		end else if (iss_s2) begin
			if (match_s2 && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_s2;
				hit_live_q <= live;
			end
			if (!valid_s2 && !emp_q) begin
				emp_q     <= 1'b1;
				emp_idx_q <= idx_s2;
			end
			if (older) begin
				best_age_q  <= age_s2;
				best_idx_q  <= idx_s2;
				best_live_q <= live;
			end
			if (live) begin
				live_cnt_q <= live_cnt_q + 1'b1;
			end
		end
	end

	// refresh the matching slot, else fill the first empty one, else evict the oldest
	always_comb begin
		if (hit_q) begin
			pick_idx  = hit_idx_q;
			pick_live = hit_live_q;
		end else if (emp_q) begin
			pick_idx  = emp_idx_q;
			pick_live = 1'b0;
		end else begin
			pick_idx  = best_idx_q;
			pick_live = best_live_q;
		end
		rec_we = cmd.commit && (op_q == OP_EVENT);
		if (op_q == OP_EVENT) begin
			cnt_new = live_cnt_q - CNT_W'(pick_live) + CNT_W'(1);
		end else begin
			cnt_new = live_cnt_q;
		end
		if (CNT_W > OUT_CNT_W && cnt_new > CNT_W'(COUNT_MAX)) begin
			cnt_sat = COUNT_MAX;
		end else begin
			cnt_sat = OUT_CNT_W'(cnt_new);
		end
		alarm = (cnt_sat >= threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else begin
			if (iss_s2 && expired) begin
				slot_valid_q[idx_s2] <= 1'b0;
			end
			if (rec_we) begin
				slot_valid_q[pick_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= M_TDATA_W'({alarm, cnt_sat});
		end
	end

	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;
	assign status.out_busy = m_tvalid_q && !m_tready;

	a_drained_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !iss_s1 && !iss_s2)
		else $error("commit while table reads still in flight");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_cnt_q <= CNT_W'(ENTRIES))
		else $error("live count exceeds table size");

	a_record_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |=> slot_valid_q[$past(pick_idx)])
		else $error("recorded slot not marked live");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.commit))
		else $error("result raised without commit");

endmodule

// ===== rtl/recent_source_table_alarm.sv =====
// after a request is taken the sequencer walks the slot ram serially (one read per cycle),
//   lets the read and age stages drain, then commits the slot update and the result; the
//   commit waits while the output register holds a result that the receiver has not taken,
//   and a new request is only taken once the sequencer is back in idle after that commit
// a new request is taken while the previous result still waits in the output register
// reset: arst_n asynchronous, active low; clears all slot live flags, the handshakes and
//   loads timeout_ticks = 3840, alarm_threshold = 3; slot address/time ram is not cleared
module recent_source_table_alarm import rsta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] node_addr, [47:16] now
	input  logic                  s_tuser,   // [0] op: 0 event, 1 tick
	// result channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [4:0] recent_count, [5] alarm, [7:6] zero
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	rsta_cmd_t         cmd;
	rsta_status_t      status;
	logic [TIME_W-1:0] timeout_q;
	logic [THR_W-1:0]  threshold_q;

	// register file: always ready, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIMEOUT: begin
					timeout_q <= cfg_data[TIME_W-1:0];
				end
				CFG_THRESHOLD: begin
					threshold_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer: idle, walk all slots, drain the read pipe, commit the update and result
	rsta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: slot ram, live flags, age compare, scan results and output register
	// the walk finds a matching live slot, the first empty slot, the oldest slot and
	// expires stale slots in the same pass; on an event the commit then writes the picked slot
	rsta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.timeout   (timeout_q),
		.threshold (threshold_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== verif/rsta_census_checker.sv =====
module rsta_census_checker import rsta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [OUT_CNT_W-1:0] count;
		logic                 alarm;
	} census_t;

	// shadow of the source table and the registers
	logic              shadow_live  [ENTRIES];
	logic [ADDR_W-1:0] shadow_addr  [ENTRIES];
	logic [TIME_W-1:0] shadow_stamp [ENTRIES];
	logic [TIME_W-1:0] shadow_timeout;
	logic [THR_W-1:0]  shadow_threshold;

	census_t census_q[$];

	// record the source (events only), sweep expired slots, count the rest
	function automatic census_t update_table(logic op, logic [ADDR_W-1:0] addr,
			logic [TIME_W-1:0] now);
		int hit;
		int pick;
		int live;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] oldest;
		census_t res;
		hit = -1;
		pick = -1;
		live = 0;
		if (op == OP_EVENT) begin
			for (int k = 0; k < ENTRIES; k++)
				if (hit < 0 && shadow_live[k] && shadow_addr[k] == addr)
					hit = k;
			if (hit >= 0) begin
				shadow_stamp[hit] = now;
			end else begin
				for (int k = 0; k < ENTRIES; k++)
					if (pick < 0 && !shadow_live[k])
						pick = k;
				if (pick < 0) begin
					// table full: oldest slot goes, lowest index on a tie
					pick = 0;
					oldest = now - shadow_stamp[0];
					for (int k = 1; k < ENTRIES; k++) begin
						age = now - shadow_stamp[k];
						if (age > oldest) begin
							oldest = age;
							pick = k;
						end
					end
				end
				shadow_live[pick] = 1'b1;
				shadow_addr[pick] = addr;
				shadow_stamp[pick] = now;
			end
		end
		for (int k = 0; k < ENTRIES; k++) begin
			if (shadow_live[k]) begin
				age = now - shadow_stamp[k];
				if (age <= shadow_timeout)
					live++;
				else
					shadow_live[k] = 1'b0;
			end
		end
		if (live > 31)
			live = 31;
		res.count = live[OUT_CNT_W-1:0];
		res.alarm = (live >= int'(shadow_threshold));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		census_t want;
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++)
				shadow_live[k] = 1'b0;
			shadow_timeout = TIMEOUT_RST;
			shadow_threshold = THRESHOLD_RST;
			census_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TIMEOUT)
					shadow_timeout = cfg_data[TIME_W-1:0];
				else if (cfg_index == CFG_THRESHOLD)
					shadow_threshold = cfg_data[THR_W-1:0];
			end
			// results first, so a stray result never meets this edge's request
			if (m_tvalid && m_tready) begin
				if (census_q.size() == 0) begin
					$error("result with nothing expected: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = census_q.pop_front();
					if (m_tdata[OUT_CNT_W-1:0] !== want.count) begin
						$error("recent_count: expected %0d, actual %0d",
							want.count, m_tdata[OUT_CNT_W-1:0]);
						fail_count++;
					end
					if (m_tdata[OUT_CNT_W] !== want.alarm) begin
						$error("alarm: expected %0b, actual %0b",
							want.alarm, m_tdata[OUT_CNT_W]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				census_q.push_back(update_table(s_tuser, s_tdata[ADDR_W-1:0],
					s_tdata[ADDR_W +: TIME_W]));
			pending = census_q.size();
		end
	end

endmodule

// ===== verif/tb_recent_source_table_alarm.sv =====
module tb_recent_source_table_alarm;
	import rsta_pkg::*;

	// receiver hold-off length in cycles
	localparam int HOLDOFF_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;    // [15:0] node_addr, [47:16] now
	logic                  s_tuser;    // [0] op
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;    // [4:0] recent_count, [5] alarm
	logic                  cfg_valid;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  cfg_ready;

	int fail_count;
	int pending;

	// sender pacing and hold-off bookkeeping
	int burst_left;
	int holdoffs_asked;
	int holdoffs_served;

	// running clock value carried by requests, and the source address pool
	logic [TIME_W-1:0] clock_now;
	logic [ADDR_W-1:0] node_pool[32];

	recent_source_table_alarm u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rsta_census_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock, period 8
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// receiver: runs of ready and stall, plus long hold-offs on request
	initial begin
		int run_left;
		logic run_level;
		run_left = 0;
		run_level = 1'b1;
		holdoffs_served = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holdoffs_served < holdoffs_asked) begin
				// long stall so the block backs up into its request side
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoffs_served++;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: begin
							run_level = 1'b1;
							run_left = $urandom_range(1, 8);
						end
						5, 6, 7: begin
							run_level = 1'b0;
							run_left = $urandom_range(1, 6);
						end
						default: begin
							// stretch with no stalls at all
							run_level = 1'b1;
							run_left = $urandom_range(30, 80);
						end
					endcase
				end
				m_tready <= run_level;
				run_left--;
			end
		end
	end

	// one request; valid stays high afterwards so bursts run back to back
	task automatic send_request(logic op, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now, addr};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// random gap between bursts of random length
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// sender stops until every expected result is back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one traffic phase: mostly events from a small pool of sources so the
	// table fills, refreshes and replaces; some ticks, stray addresses and
	// odd time steps (none, huge jumps, backwards)
	task automatic run_traffic(int items, int step_max, int pool_n, bit with_holdoff);
		logic op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] step;
		int r;
		for (int k = 0; k < pool_n; k++)
			node_pool[k] = ADDR_W'($urandom_range(0, 16'hFFFF));
		if (with_holdoff)
			holdoffs_asked++;
		for (int n = 0; n < items; n++) begin
			// the first requests after a hold-off go out without gaps
			if (!with_holdoff || n >= 12)
				pace_sender();
			op = ($urandom_range(0, 99) < 15) ? OP_TICK : OP_EVENT;
			addr = ($urandom_range(0, 99) < 15) ? ADDR_W'($urandom_range(0, 16'hFFFF))
				: node_pool[$urandom_range(0, pool_n - 1)];
			r = $urandom_range(0, 99);
			if (r < 10)
				step = '0;
			else if (r < 85)
				step = $urandom_range(0, step_max);
			else if (r < 95)
				step = $urandom;
			else
				step = -$urandom_range(1, step_max + 1);
			clock_now = clock_now + step;
			send_request(op, addr, clock_now);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_EVENT;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = '0;
		burst_left = 0;
		holdoffs_asked = 0;
		clock_now = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset settings: timeout 3840, threshold 3
		send_request(OP_TICK, 16'hFFFF, 32'd0);             // empty table
		send_request(OP_EVENT, 16'h0000, 32'd100);
		send_request(OP_EVENT, 16'hFFFF, 32'd100);
		for (int k = 2; k < ENTRIES; k++)
			send_request(OP_EVENT, ADDR_W'(16'h1000 + k), 32'd100);  // all slots same age
		send_request(OP_EVENT, 16'h7777, 32'd100);          // full, tie: lowest slot goes
		send_request(OP_EVENT, 16'hFFFF, 32'd100);          // refresh a live source
		send_request(OP_TICK, 16'h0000, 32'd3940);           // age equal to timeout, kept
		send_request(OP_TICK, 16'h1234, 32'd3941);           // one past timeout, all expire
		send_request(OP_EVENT, 16'hA5A5, 32'hFFFF_FFFF);
		send_request(OP_EVENT, 16'h5A5A, 32'd5);             // across the time wrap
		send_request(OP_TICK, 16'h0000, 32'hFFFF_FFF0);      // stamps now in the future
		drain();

		// reset settings, with a long receiver hold-off
		clock_now = 32'd50_000;
		run_traffic(100, 400, 24, 1'b1);

		// zero timeout: only same-time entries survive; alarm on any live slot
		write_register(CFG_TIMEOUT, 32'd0);
		write_register(CFG_THRESHOLD, 32'd1);
		run_traffic(80, 2, 6, 1'b0);

		// nothing ever expires, table fills and stays full, alarm only when full
		write_register(CFG_TIMEOUT, 32'hFFFF_FFFF);
		write_register(CFG_THRESHOLD, 32'd16);
		run_traffic(110, 1000, 28, 1'b0);

		// zero threshold: alarm always up
		write_register(CFG_THRESHOLD, 32'd0);
		run_traffic(60, 50, 20, 1'b0);

		// top threshold, never reached, upper data bits set
		write_register(CFG_TIMEOUT, 32'd500);
		write_register(CFG_THRESHOLD, 32'hFFFF_FFFF);
		run_traffic(90, 60, 20, 1'b1);

		// writes to unknown indexes are dropped
		write_register(CFG_TIMEOUT, 32'd3840);
		write_register(CFG_THRESHOLD, 32'd8);
		write_register(8'd2, 32'd7);
		write_register(8'hFF, 32'h0000_0001);
		run_traffic(90, 300, 20, 1'b0);

		// random settings
		write_register(CFG_TIMEOUT, $urandom_range(100, 20_000));
		write_register(CFG_THRESHOLD, $urandom_range(1, 16));
		run_traffic(100, 2_000, 18, 1'b0);

		// half-range timeout
		write_register(CFG_TIMEOUT, 32'h7FFF_FFFF);
		write_register(CFG_THRESHOLD, 32'd3);
		run_traffic(100, 5_000, 22, 1'b0);

		// let anything stray come out before the verdict
		repeat (ENTRIES + 8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rsta_pkg.sv
rtl/rsta_ram.sv
rtl/rsta_ctrl.sv
rtl/rsta_dp.sv
rtl/recent_source_table_alarm.sv
verif/rsta_census_checker.sv
verif/tb_recent_source_table_alarm.sv
